/* sv/mhtq_pkg.sv */
`default_nettype none
package mhtq_pkg;

    localparam logic [2:0] REQ_ADD   = 3'd0;
    localparam logic [2:0] REQ_RESET = 3'd1;
    localparam logic [2:0] REQ_TICK  = 3'd2;
    localparam logic [2:0] REQ_PEEK  = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_PEEK    = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam int ID_BITS = 8;

endpackage
`default_nettype wire

/* sv/min_heap_timer_queue.sv */
// Timer queue kept as a binary min-heap on expiry time, with an id-to-slot map.
// Input channel: one request word (req_type, timer_id, timeout_ms, now_ms) is
// taken when i_in_valid is high and o_in_stall is low. o_in_stall is high from
// the word's acceptance until its last result word has been loaded into the
// output register, so one request is worked at a time.
// Output channel: result words leave a single output register, taken when
// o_out_valid is high and i_out_stall is low; last marks a request's final word.
// While the receiver stalls, the word holds and the sequencer waits on it.
// Add, and reset of a known id, walk the heap a level at a time (one heap
// memory read then one compare/write per level, log2(CAPACITY) levels at most);
// clear and rejected requests walk no levels. Tick and peek, per expired timer,
// move the last entry, if any, to the root and sift it down the same way.
// The one-read-per-level walk of the heap memory sets the pace of a request.
// Reset: synchronous, active low; empties the heap and drops the output valid.
// No clearing pass: an id counts as pending only when its mapped slot is below
// the entry count and that heap slot holds the same id.
`default_nettype none
module min_heap_timer_queue
    import mhtq_pkg::*;
#(
    parameter int CAPACITY  = 32,
    parameter int ID_COUNT  = 256,
    parameter int TIME_BITS = 48
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [7:0]  i_timer_id,
    input  wire logic [31:0] i_timeout_ms,
    input  wire logic [47:0] i_now_ms,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_result_kind,
    output logic [7:0]       o_expired_id,
    output logic [31:0]      o_remaining_ms,
    output logic             o_heap_empty,
    output logic [1:0]       o_status,
    output logic             o_last
);

    localparam int TB  = TIME_BITS;
    localparam int PW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int IDW = (ID_COUNT > 2) ? $clog2(ID_COUNT) : 1;
    localparam int HDW = ID_BITS + TB;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LOOK     = 4'd1;
    localparam logic [3:0] S_CHECK    = 4'd2;
    localparam logic [3:0] S_UP_RD    = 4'd3;
    localparam logic [3:0] S_UP_CMP   = 4'd4;
    localparam logic [3:0] S_DN_RD    = 4'd5;
    localparam logic [3:0] S_DN_CMP   = 4'd6;
    localparam logic [3:0] S_FIN      = 4'd7;
    localparam logic [3:0] S_ACK      = 4'd8;
    localparam logic [3:0] S_EXP_RD   = 4'd9;
    localparam logic [3:0] S_EXP_CMP  = 4'd10;
    localparam logic [3:0] S_EXP_LAST = 4'd11;
    localparam logic [3:0] S_EXP_MV   = 4'd12;
    localparam logic [3:0] S_EXP_END  = 4'd13;

    logic [3:0]          r_state, n_state;
    logic [2:0]          r_req, n_req;
    logic [ID_BITS-1:0]  r_id, n_id;
    logic [TB-1:0]       r_exp, n_exp;
    logic [TB-1:0]       r_now, n_now;
    logic                r_idx_ok, n_idx_ok;
    logic [CW-1:0]       r_count, n_count;
    logic [PW-1:0]       r_hole, n_hole;
    logic [ID_BITS-1:0]  r_cur_id, n_cur_id;
    logic [TB-1:0]       r_cur_exp, n_cur_exp;
    logic                r_try_down, n_try_down;
    logic                r_moved, n_moved;
    logic [1:0]          r_status, n_status;
    logic                r_pend_v, n_pend_v;
    logic [ID_BITS-1:0]  r_pend_id, n_pend_id;
    logic [TB-1:0]       r_top_exp, n_top_exp;
    logic                r_empty, n_empty;

    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_kind, n_kind;
    logic [7:0]          r_oid, n_oid;
    logic [31:0]         r_rem, n_rem;
    logic                r_oempty, n_oempty;
    logic [1:0]          r_ostatus, n_ostatus;
    logic                r_last, n_last;

    logic                heap_we;
    logic [PW-1:0]       heap_waddr, heap_ra_a, heap_ra_b;
    logic [HDW-1:0]      heap_wdata, heap_rd_a, heap_rd_b;
    logic                slot_we;
    logic [IDW-1:0]      slot_waddr, slot_raddr;
    logic [PW-1:0]       slot_wdata, slot_rd;

    logic [16:0]         id_ext;
    logic                in_range;
    logic [TB-1:0]       now_t;
    logic [TB:0]         sum;
    logic [TB-1:0]       exp_sat;
    logic                acc;
    logic                out_free;
    logic [ID_BITS-1:0]  a_id, b_id;
    logic [TB-1:0]       a_exp, b_exp;
    logic [PW-1:0]       parent;
    logic [CW:0]         lchild, rchild;
    logic                rch_ok;
    logic                known;
    logic [TB-1:0]       m_exp;
    logic [1:0]          sel;
    logic [CW-1:0]       lastpos;
    logic [TB-1:0]       diff;
    logic [31:0]         rem32;

    mhtq_heap_ram #(.DEPTH(CAPACITY), .AW(PW), .DW(HDW)) u_heap (
        .i_clk     (i_clk),
        .i_we      (heap_we),
        .i_waddr   (heap_waddr),
        .i_wdata   (heap_wdata),
        .i_raddr_a (heap_ra_a),
        .i_raddr_b (heap_ra_b),
        .o_rdata_a (heap_rd_a),
        .o_rdata_b (heap_rd_b)
    );

    mhtq_slot_ram #(.DEPTH(ID_COUNT), .AW(IDW), .DW(PW)) u_slot (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rd)
    );

    assign id_ext   = {9'd0, i_timer_id};
    assign in_range = id_ext < 17'(ID_COUNT);
    assign now_t    = TB'(i_now_ms);
    assign sum      = {1'b0, now_t} + (TB + 1)'(i_timeout_ms);
    assign exp_sat  = sum[TB] ? '1 : sum[TB-1:0];
    assign acc      = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign a_id  = heap_rd_a[HDW-1:TB];
    assign a_exp = heap_rd_a[TB-1:0];
    assign b_id  = heap_rd_b[HDW-1:TB];
    assign b_exp = heap_rd_b[TB-1:0];

    assign parent  = (r_hole - PW'(1)) >> 1;
    assign lchild  = ((CW + 1)'(r_hole) << 1) + (CW + 1)'(1);
    assign rchild  = lchild + (CW + 1)'(1);
    assign rch_ok  = rchild < (CW + 1)'(r_count);
    assign known   = r_idx_ok && (CW'(r_hole) < r_count) && (a_id == r_id);
    assign lastpos = r_count - CW'(1);
    assign diff    = (r_top_exp > r_now) ? (r_top_exp - r_now) : '0;
    assign rem32   = ((diff >> 32) != '0) ? 32'hFFFF_FFFF : diff[31:0];

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_expired_id   = r_oid;
    assign o_remaining_ms = r_rem;
    assign o_heap_empty   = r_oempty;
    assign o_status       = r_ostatus;
    assign o_last         = r_last;

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_id       = r_id;
        n_exp      = r_exp;
        n_now      = r_now;
        n_idx_ok   = r_idx_ok;
        n_count    = r_count;
        n_hole     = r_hole;
        n_cur_id   = r_cur_id;
        n_cur_exp  = r_cur_exp;
        n_try_down = r_try_down;
        n_moved    = r_moved;
        n_status   = r_status;
        n_pend_v   = r_pend_v;
        n_pend_id  = r_pend_id;
        n_top_exp  = r_top_exp;
        n_empty    = r_empty;

        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_oid       = r_oid;
        n_rem       = r_rem;
        n_oempty    = r_oempty;
        n_ostatus   = r_ostatus;
        n_last      = r_last;

        heap_we    = 1'b0;
        heap_waddr = r_hole;
        heap_wdata = {r_cur_id, r_cur_exp};
        heap_ra_a  = '0;
        heap_ra_b  = '0;
        slot_we    = 1'b0;
        slot_waddr = IDW'(r_cur_id);
        slot_wdata = r_hole;
        slot_raddr = id_ext[IDW-1:0];
        m_exp      = r_cur_exp;
        sel        = 2'd0;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_req    = i_req_type;
                    n_id     = i_timer_id;
                    n_exp    = exp_sat;
                    n_now    = now_t;
                    n_idx_ok = in_range;
                    n_state  = S_LOOK;
                end
            end
            S_LOOK: begin
                n_hole    = slot_rd;
                heap_ra_a = slot_rd;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                n_status = ST_OK;
                n_state  = S_ACK;
                unique case (r_req)
                    REQ_ADD: begin
                        if (!r_idx_ok) begin
                            n_status = ST_UNKNOWN;
                        end else if (known) begin
                            n_cur_id   = r_id;
                            n_cur_exp  = r_exp;
                            n_try_down = 1'b1;
                            n_moved    = 1'b0;
                            n_state    = S_UP_RD;
                        end else if (r_count == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            n_cur_id   = r_id;
                            n_cur_exp  = r_exp;
                            n_hole     = PW'(r_count);
                            n_count    = r_count + CW'(1);
                            n_try_down = 1'b0;
                            n_moved    = 1'b0;
                            n_state    = S_UP_RD;
                        end
                    end
                    REQ_RESET: begin
                        if (known) begin
                            n_cur_id   = r_id;
                            n_cur_exp  = r_exp;
                            n_try_down = 1'b1;
                            n_moved    = 1'b0;
                            n_state    = S_UP_RD;
                        end else begin
                            n_status = ST_UNKNOWN;
                        end
                    end
                    REQ_TICK, REQ_PEEK: begin
                        n_pend_v = 1'b0;
                        n_state  = S_EXP_RD;
                    end
                    REQ_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_UP_RD: begin
                if (r_hole == '0) begin
                    n_state = (r_try_down && !r_moved) ? S_DN_RD : S_FIN;
                end else begin
                    heap_ra_a = parent;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (r_cur_exp < a_exp) begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rd_a;
                    slot_we    = 1'b1;
                    slot_waddr = IDW'(a_id);
                    n_hole     = parent;
                    n_moved    = 1'b1;
                    n_state    = S_UP_RD;
                end else begin
                    n_state = (r_try_down && !r_moved) ? S_DN_RD : S_FIN;
                end
            end
            S_DN_RD: begin
                if (lchild >= (CW + 1)'(r_count)) begin
                    n_state = S_FIN;
                end else begin
                    heap_ra_a = PW'(lchild);
                    heap_ra_b = rch_ok ? PW'(rchild) : '0;
                    n_state   = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (a_exp < m_exp) begin
                    m_exp = a_exp;
                    sel   = 2'd1;
                end
                if (rch_ok && (b_exp < m_exp)) begin
                    sel = 2'd2;
                end
                priority if (sel == 2'd1) begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rd_a;
                    slot_we    = 1'b1;
                    slot_waddr = IDW'(a_id);
                    n_hole     = PW'(lchild);
                    n_state    = S_DN_RD;
                end else if (sel == 2'd2) begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rd_b;
                    slot_we    = 1'b1;
                    slot_waddr = IDW'(b_id);
                    n_hole     = PW'(rchild);
                    n_state    = S_DN_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                heap_we = 1'b1;
                slot_we = 1'b1;
                if (r_req == REQ_TICK || r_req == REQ_PEEK) begin
                    n_state = S_EXP_RD;
                end else begin
                    n_status = ST_OK;
                    n_state  = S_ACK;
                end
            end
            S_ACK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_ACK;
                    n_oid       = '0;
                    n_rem       = '0;
                    n_oempty    = 1'b0;
                    n_ostatus   = r_status;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_EXP_RD: begin
                if (r_count == '0) begin
                    n_empty = 1'b1;
                    n_state = S_EXP_END;
                end else begin
                    heap_ra_a = '0;
                    n_state   = S_EXP_CMP;
                end
            end
            S_EXP_CMP: begin
                if (a_exp <= r_now) begin
                    if (!(r_pend_v && !out_free)) begin
                        if (r_pend_v) begin
                            n_out_valid = 1'b1;
                            n_kind      = KIND_EXPIRED;
                            n_oid       = r_pend_id;
                            n_rem       = '0;
                            n_oempty    = 1'b0;
                            n_ostatus   = ST_OK;
                            n_last      = 1'b0;
                        end
                        n_pend_v  = 1'b1;
                        n_pend_id = a_id;
                        n_count   = lastpos;
                        n_state   = (lastpos == '0) ? S_EXP_RD : S_EXP_LAST;
                    end
                end else begin
                    n_top_exp = a_exp;
                    n_empty   = 1'b0;
                    n_state   = S_EXP_END;
                end
            end
            S_EXP_LAST: begin
                heap_ra_a = PW'(r_count);
                n_state   = S_EXP_MV;
            end
            S_EXP_MV: begin
                n_cur_id  = a_id;
                n_cur_exp = a_exp;
                n_hole    = '0;
                n_state   = S_DN_RD;
            end
            S_EXP_END: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_oid       = '0;
                    n_rem       = '0;
                    n_oempty    = 1'b0;
                    n_ostatus   = ST_OK;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                    if (r_pend_v) begin
                        n_kind = KIND_EXPIRED;
                        n_oid  = r_pend_id;
                        if (r_req != REQ_TICK) begin
                            n_last   = 1'b0;
                            n_pend_v = 1'b0;
                            n_state  = S_EXP_END;
                        end
                    end else if (r_req == REQ_TICK) begin
                        n_kind = KIND_ACK;
                    end else begin
                        n_kind   = KIND_PEEK;
                        n_oempty = r_empty;
                        n_rem    = r_empty ? 32'd0 : rem32;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
        r_req      <= n_req;
        r_id       <= n_id;
        r_exp      <= n_exp;
        r_now      <= n_now;
        r_idx_ok   <= n_idx_ok;
        r_hole     <= n_hole;
        r_cur_id   <= n_cur_id;
        r_cur_exp  <= n_cur_exp;
        r_try_down <= n_try_down;
        r_moved    <= n_moved;
        r_status   <= n_status;
        r_pend_id  <= n_pend_id;
        r_top_exp  <= n_top_exp;
        r_empty    <= n_empty;
        r_kind     <= n_kind;
        r_oid      <= n_oid;
        r_rem      <= n_rem;
        r_oempty   <= n_oempty;
        r_ostatus  <= n_ostatus;
        r_last     <= n_last;
    end

endmodule
`default_nettype wire

/* sv/mhtq_heap_ram.sv */
`default_nettype none
module mhtq_heap_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 56
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr_a,
    input  wire logic [AW-1:0] i_raddr_b,
    output logic      [DW-1:0] o_rdata_a,
    output logic      [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

/* sv/mhtq_slot_ram.sv */
`default_nettype none
module mhtq_slot_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* sv/mhtq_checker.sv */
`default_nettype none
module mhtq_checker
    import mhtq_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [2:0]  i_req_type,
    input wire logic [7:0]  i_timer_id,
    input wire logic [31:0] i_timeout_ms,
    input wire logic [47:0] i_now_ms,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_result_kind,
    input wire logic [7:0]  o_expired_id,
    input wire logic [31:0] o_remaining_ms,
    input wire logic        o_heap_empty,
    input wire logic [1:0]  o_status,
    input wire logic        o_last
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_expired_id)
            && $stable(o_result_kind) && $stable(o_last))
        else $error("stalled output word changed");

    a_single_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == KIND_ACK || o_result_kind == KIND_PEEK)
            |-> o_last)
        else $error("ack or peek word not final");

    a_expired_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_EXPIRED
            |-> o_status == ST_OK && o_remaining_ms == 32'd0 && !o_heap_empty)
        else $error("expired word carries stray fields");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken before first finished");

endmodule

bind min_heap_timer_queue mhtq_checker u_mhtq_checker (.*);
`default_nettype wire

/* tb/min_heap_timer_queue_test.sv */
`default_nettype none
module min_heap_timer_queue_test;
    import mhtq_pkg::*;

    localparam int CAP = 32;
    localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  req;
        logic [7:0]  id;
        logic [31:0] timeout;
        logic [47:0] now;
    } t_req_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  id;
        logic [31:0] rem;
        logic        empty;
        logic [1:0]  status;
        logic        last;
    } t_res_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [2:0]  i_req_type = '0;
    logic [7:0]  i_timer_id = '0;
    logic [31:0] i_timeout_ms = '0;
    logic [47:0] i_now_ms = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall, o_out_valid, o_heap_empty, o_last;
    logic [1:0]  o_result_kind, o_status;
    logic [7:0]  o_expired_id;
    logic [31:0] o_remaining_ms;

    min_heap_timer_queue u_top (.*);

    initial forever #5 i_clk = ~i_clk;

    // predictor state
    logic [47:0] hx_exp [CAP];
    logic [7:0]  hx_id [CAP];
    int          slot_map [256];
    bit          pending [256];
    int          n_timers;

    t_req_word   pending_reqs [$];
    t_res_word   expected_results [$];
    int          errors = 0;
    int          n_expired = 0, n_peeks = 0, n_full = 0;
    bit          hold_sender = 0;
    bit          no_idle = 0;
    bit          hold_req = 0;
    int          recv_hold = 0;
    logic [47:0] now_clk = 48'd1000;

    function automatic void swap_slots(int a, int b);
        logic [47:0] te;
        logic [7:0] ti;
        te = hx_exp[a]; ti = hx_id[a];
        hx_exp[a] = hx_exp[b]; hx_id[a] = hx_id[b];
        hx_exp[b] = te; hx_id[b] = ti;
        slot_map[hx_id[a]] = a;
        slot_map[hx_id[b]] = b;
    endfunction

    function automatic void sift_up(int i);
        while (i > 0 && hx_exp[i] < hx_exp[(i - 1) / 2]) begin
            swap_slots(i, (i - 1) / 2);
            i = (i - 1) / 2;
        end
    endfunction

    function automatic void sift_down(int i);
        int m, l, r;
        forever begin
            m = i; l = 2 * i + 1; r = l + 1;
            if (l < n_timers && hx_exp[l] < hx_exp[m]) m = l;
            if (r < n_timers && hx_exp[r] < hx_exp[m]) m = r;
            if (m == i) break;
            swap_slots(i, m);
            i = m;
        end
    endfunction

    function automatic void rearm(int s, logic [47:0] x);
        hx_exp[s] = x;
        if (s > 0 && hx_exp[s] < hx_exp[(s - 1) / 2]) sift_up(s);
        else sift_down(s);
    endfunction

    function automatic void push_result(logic [1:0] kind, logic [7:0] id, logic [31:0] rem,
                                        logic empty, logic [1:0] st, logic last);
        t_res_word w;
        w = '{kind: kind, id: id, rem: rem, empty: empty, status: st, last: last};
        expected_results.insert(expected_results.size(), w);
    endfunction

    function automatic int expire_due(logic [47:0] now);
        int n, lp;
        n = 0;
        while (n_timers > 0 && hx_exp[0] <= now && n < CAP) begin
            push_result(KIND_EXPIRED, hx_id[0], '0, 1'b0, ST_OK, 1'b0);
            n++;
            lp = n_timers - 1;
            if (lp > 0) swap_slots(0, lp);
            pending[hx_id[lp]] = 0;
            n_timers = lp;
            if (n_timers > 0) sift_down(0);
        end
        n_expired += n;
        return n;
    endfunction

    function automatic void predict_request(t_req_word q);
        logic [48:0] sum;
        logic [47:0] x;
        logic [48:0] diff;
        logic [31:0] rem;
        int n, s;
        sum = {1'b0, q.now} + {17'd0, q.timeout};
        x = sum[48] ? TMAX : sum[47:0];
        case (q.req)
            REQ_ADD: begin
                if (pending[q.id]) begin
                    rearm(slot_map[q.id], x);
                    push_result(KIND_ACK, '0, '0, 1'b0, ST_OK, 1'b1);
                end else if (n_timers >= CAP) begin
                    n_full++;
                    push_result(KIND_ACK, '0, '0, 1'b0, ST_FULL, 1'b1);
                end else begin
                    s = n_timers;
                    hx_exp[s] = x; hx_id[s] = q.id;
                    slot_map[q.id] = s; pending[q.id] = 1;
                    n_timers++;
                    sift_up(s);
                    push_result(KIND_ACK, '0, '0, 1'b0, ST_OK, 1'b1);
                end
            end
            REQ_RESET: begin
                if (pending[q.id]) begin
                    rearm(slot_map[q.id], x);
                    push_result(KIND_ACK, '0, '0, 1'b0, ST_OK, 1'b1);
                end else begin
                    push_result(KIND_ACK, '0, '0, 1'b0, ST_UNKNOWN, 1'b1);
                end
            end
            REQ_TICK: begin
                n = expire_due(q.now);
                if (n == 0) push_result(KIND_ACK, '0, '0, 1'b0, ST_OK, 1'b1);
                else expected_results[$].last = 1'b1;
            end
            REQ_PEEK: begin
                n = expire_due(q.now);
                n_peeks++;
                if (n_timers == 0) begin
                    push_result(KIND_PEEK, '0, '0, 1'b1, ST_OK, 1'b1);
                end else begin
                    diff = (hx_exp[0] > q.now) ? {1'b0, hx_exp[0]} - {1'b0, q.now} : '0;
                    rem = (diff > 49'hFFFF_FFFF) ? 32'hFFFF_FFFF : diff[31:0];
                    push_result(KIND_PEEK, '0, rem, 1'b0, ST_OK, 1'b1);
                end
            end
            REQ_CLEAR: begin
                foreach (pending[k]) pending[k] = 0;
                n_timers = 0;
                push_result(KIND_ACK, '0, '0, 1'b0, ST_OK, 1'b1);
            end
            default: push_result(KIND_ACK, '0, '0, 1'b0, ST_OK, 1'b1);
        endcase
    endfunction

    task automatic queue_request(logic [2:0] r, logic [7:0] id, logic [31:0] t, logic [47:0] n);
        pending_reqs.insert(pending_reqs.size(), '{req: r, id: id, timeout: t, now: n});
    endtask

    // mostly well-formed traffic on a moving clock, with a few wild words
    task automatic queue_random(int count, int id_span);
        int sel;
        logic [31:0] t;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            now_clk += 48'($urandom_range(0, 40));
            t = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 200);
            if (sel < 45)
                queue_request(REQ_ADD, 8'($urandom_range(0, id_span)), t, now_clk);
            else if (sel < 60)
                queue_request(REQ_RESET, 8'($urandom_range(0, id_span)), t, now_clk);
            else if (sel < 75)
                queue_request(REQ_TICK, '0, '0, now_clk);
            else if (sel < 88)
                queue_request(REQ_PEEK, '0, '0, now_clk);
            else if (sel < 91)
                queue_request(REQ_CLEAR, 8'($urandom), $urandom, now_clk);
            else if (sel < 94)
                queue_request(3'($urandom_range(5, 7)), 8'($urandom), $urandom,
                              48'({$urandom, $urandom}));
            else
                queue_request(3'($urandom_range(0, 3)), 8'($urandom), $urandom,
                              {16'($urandom), $urandom});
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || !o_in_stall) begin
                if (pending_reqs.size() > 0 && !hold_sender
                        && (no_idle || $urandom_range(0, 99) >= 24)) begin
                    i_in_valid   <= 1'b1;
                    i_req_type   <= pending_reqs[0].req;
                    i_timer_id   <= pending_reqs[0].id;
                    i_timeout_ms <= pending_reqs[0].timeout;
                    i_now_ms     <= pending_reqs[0].now;
                    void'(pending_reqs.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            predict_request('{req: i_req_type, id: i_timer_id, timeout: i_timeout_ms,
                              now: i_now_ms});
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        t_res_word got, want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = '{kind: o_result_kind, id: o_expired_id, rem: o_remaining_ms,
                        empty: o_heap_empty, status: o_status, last: o_last};
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word %p", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    end
                end
            end
            if (hold_req) begin
                recv_hold <= 400;
                i_out_stall <= 1'b1;
            end else if (recv_hold > 0) begin
                recv_hold <= recv_hold - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !no_idle && ($urandom_range(0, 99) < 24);
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("min_heap_timer_queue_test: errors");
            $finish;
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        foreach (pending[k]) pending[k] = 0;
        n_timers = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every request, full heap, unknown id, saturation
        queue_request(REQ_PEEK, 8'hFF, 32'hFFFF_FFFF, 48'd0);
        queue_request(REQ_TICK, '0, '0, 48'd0);
        queue_request(REQ_RESET, 8'd7, 32'd5, 48'd10);
        queue_request(REQ_ADD, 8'd0, 32'd0, 48'd0);
        queue_request(REQ_ADD, 8'hFF, 32'hFFFF_FFFF, TMAX);
        queue_request(REQ_ADD, 8'd5, 32'hFFFF_FFFF, 48'd100);
        queue_request(REQ_PEEK, '0, '0, 48'd1);
        queue_request(REQ_ADD, 8'd9, 32'd50, 48'd100);
        queue_request(REQ_ADD, 8'd9, 32'd20, 48'd100);
        queue_request(REQ_RESET, 8'd5, 32'd10, 48'd100);
        queue_request(REQ_PEEK, '0, '0, 48'd105);
        queue_request(REQ_PEEK, '0, '0, 48'd100);
        queue_request(REQ_TICK, '0, '0, 48'd200);
        queue_request(REQ_ADD, 8'd1, 32'd7, 48'd300);
        queue_request(REQ_ADD, 8'd2, 32'd7, 48'd300);
        queue_request(3'd5, 8'hAA, 32'h5555_5555, 48'hAAAA_5555_AAAA);
        queue_request(3'd7, '0, '0, '0);
        queue_request(REQ_CLEAR, '0, '0, '0);
        queue_request(REQ_PEEK, '0, '0, TMAX);
        for (int k = 0; k < 33; k++)
            queue_request(REQ_ADD, 8'(k + 40), 32'(k * 3), 48'd500);
        queue_request(REQ_TICK, '0, '0, TMAX);
        drain();

        // receiver holds off while the sender keeps offering
        queue_random(30, 40);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        drain();

        hold_sender = 1;
        drain();
        repeat (50) @(posedge i_clk);
        hold_sender = 0;

        no_idle = 1;
        queue_random(60, 40);
        drain();
        no_idle = 0;
        queue_random(180, 63);
        queue_request(REQ_TICK, '0, '0, TMAX);
        drain();
        repeat (100) @(posedge i_clk);

        $display("covered %0d expired timers, %0d peeks, %0d full-heap adds",
                 n_expired, n_peeks, n_full);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("min_heap_timer_queue_test: clean");
        end else begin
            $display("min_heap_timer_queue_test: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
